### rtl/core/cmps_pkg.sv
// shared widths, register indexes, codes and types of the cross morphology stream
package cmps_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int DIM_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef logic [CHAR_W-1:0]     char_type;
   typedef logic [DIM_W-1:0]      dim_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // register indexes
   localparam csr_idx_type CSR_MODE       = 3'd0;
   localparam csr_idx_type CSR_TARGET     = 3'd1;
   localparam csr_idx_type CSR_BACKGROUND = 3'd2;
   localparam csr_idx_type CSR_WIDTH      = 3'd3;
   localparam csr_idx_type CSR_HEIGHT     = 3'd4;

   // operation codes
   localparam logic MODE_ERODE  = 1'b0;
   localparam logic MODE_DILATE = 1'b1;
   localparam logic CMD_PIXEL   = 1'b0;
   localparam logic CMD_DRAIN   = 1'b1;

   // register reset values
   localparam char_type TARGET_RESET     = 8'd35;
   localparam char_type BACKGROUND_RESET = 8'd46;
   localparam dim_type  DIM_RESET        = 11'd1024;

   // line buffer write enables
   typedef struct packed {
      logic char_we;
      logic match_we;
   } wr_en_type;

endpackage

### rtl/core/cmps_ifs.sv
// valid/ready channel interfaces for requests, results and register writes
interface cmps_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   cmps_pkg::char_type pixel_char;

   modport source (output valid, command, pixel_char, input ready);
   modport sink   (input valid, command, pixel_char, output ready);
endinterface

interface cmps_rsp_if;
   logic               valid;
   logic               ready;
   cmps_pkg::char_type out_char;
   logic               end_of_row;
   logic               end_of_frame;

   modport source (output valid, out_char, end_of_row, end_of_frame, input ready);
   modport sink   (input valid, out_char, end_of_row, end_of_frame, output ready);
endinterface

interface cmps_csr_if;
   logic                   valid;
   logic                   ready;
   cmps_pkg::csr_idx_type  index;
   cmps_pkg::csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/cmps_line_buf.sv
// line buffer: character row with two registered read ports, match row with one
module cmps_line_buf #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  cmps_pkg::wr_en_type wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  cmps_pkg::char_type  wr_char,
   input  logic                wr_match,
   input  logic [ADDR_W-1:0]   rd_a_addr,
   input  logic [ADDR_W-1:0]   rd_b_addr,
   output cmps_pkg::char_type  rd_a_char,
   output logic                rd_a_match,
   output cmps_pkg::char_type  rd_b_char
);

   cmps_pkg::char_type char_mem [DEPTH];
   logic               match_mem [DEPTH];

   cmps_pkg::char_type rd_a_char_ff;
   logic               rd_a_match_ff;
   cmps_pkg::char_type rd_b_char_ff;

   // writes
   always_ff @(posedge clock) begin
      if (wr_en.char_we) begin
         char_mem[wr_addr] <= wr_char;
      end
      if (wr_en.match_we) begin
         match_mem[wr_addr] <= wr_match;
      end
   end

   // registered reads, same-cycle write data forwarded
   always_ff @(posedge clock) begin
      if (wr_en.char_we && (wr_addr == rd_a_addr)) begin
         rd_a_char_ff <= wr_char;
      end else begin
         rd_a_char_ff <= char_mem[rd_a_addr];
      end
      if (wr_en.char_we && (wr_addr == rd_b_addr)) begin
         rd_b_char_ff <= wr_char;
      end else begin
         rd_b_char_ff <= char_mem[rd_b_addr];
      end
      if (wr_en.match_we && (wr_addr == rd_a_addr)) begin
         rd_a_match_ff <= wr_match;
      end else begin
         rd_a_match_ff <= match_mem[rd_a_addr];
      end
   end

   assign rd_a_char  = rd_a_char_ff;
   assign rd_a_match = rd_a_match_ff;
   assign rd_b_char  = rd_b_char_ff;

endmodule

### rtl/core/cross_morphology_pixel_stream.sv
// top level: 4-neighbour cross erosion / dilation over a raster character stream
//
// Pixels of an image_width x image_height frame come in raster order, one
// request per clock, and each result is loaded into an output register in the
// cycle after the request that causes it; a request is taken whenever that
// register is empty or being emptied. Output lags input by one row: the first
// row gives no results and the last row is flushed by drain requests, one
// pixel each. The current and next row share one line buffer of MAX_WIDTH
// characters plus a match bit per column; its reads are registered and are
// addressed ahead from the next frame position, which keeps the rate at one
// request per clock. The line buffer needs no clearing after reset. Writing
// image_width or image_height restarts the frame.
module cross_morphology_pixel_stream #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input logic        clock,
   input logic        reset,
   cmps_req_if.sink   req_ch,
   cmps_rsp_if.source rsp_ch,
   cmps_csr_if.sink   csr_ch
);

   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W     = ((COL_W > cmps_pkg::DIM_W) ? COL_W : cmps_pkg::DIM_W) + 1;
   localparam int DIM_LIMIT = (2 ** cmps_pkg::DIM_W) - 1;
   localparam cmps_pkg::dim_type W_LIM =
      cmps_pkg::dim_type'((MAX_WIDTH > DIM_LIMIT) ? DIM_LIMIT : MAX_WIDTH);
   localparam cmps_pkg::dim_type H_LIM =
      cmps_pkg::dim_type'((MAX_HEIGHT > DIM_LIMIT) ? DIM_LIMIT : MAX_HEIGHT);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

   // configuration registers
   logic               mode_ff;
   cmps_pkg::char_type target_ff;
   cmps_pkg::char_type background_ff;
   cmps_pkg::dim_type  width_ff;
   cmps_pkg::dim_type  height_ff;

   // frame position
   logic [COL_W-1:0]  col_ff, col_in;
   cmps_pkg::dim_type row_ff, row_in;
   logic              draining_ff, draining_in;
   logic              left_match_ff, left_match_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   cmps_pkg::char_type out_char_ff, out_char_in;
   logic               end_of_row_ff;
   logic               end_of_frame_ff;

   // line buffer connections
   cmps_pkg::wr_en_type wr_en;
   logic [COL_W-1:0]    rd_b_addr;
   cmps_pkg::char_type  center_char;
   logic                up_match;
   cmps_pkg::char_type  right_char;

   logic              req_ready;
   logic              accept;
   logic              is_pixel;
   logic              is_drain;
   logic              emit;
   logic              restart;
   cmps_pkg::dim_type eff_w;
   cmps_pkg::dim_type eff_h;
   logic [CMP_W-1:0]  col_p1;
   logic              col_end;
   logic              row_end;
   logic              c_m, up_e, dn_e, dn_m, lf_e, rt_e, rt_m;
   logic              erode_ok, dilate_hit;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = cmps_pkg::dim_type'(1);
      end else if (width_ff > W_LIM) begin
         eff_w = W_LIM;
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = cmps_pkg::dim_type'(1);
      end else if (height_ff > H_LIM) begin
         eff_h = H_LIM;
      end else begin
         eff_h = height_ff;
      end
   end

   // handshake and request decode
   assign req_ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ready;
   assign is_pixel  = accept && (req_ch.command == cmps_pkg::CMD_PIXEL) && !draining_ff;
   assign is_drain  = accept && (req_ch.command == cmps_pkg::CMD_DRAIN) && draining_ff;
   assign emit      = (is_pixel && (row_ff != '0)) || is_drain;
   assign restart   = csr_ch.valid &&
                      ((csr_ch.index == cmps_pkg::CSR_WIDTH) ||
                       (csr_ch.index == cmps_pkg::CSR_HEIGHT));

   // position compares
   assign col_p1  = CMP_W'(col_ff) + CMP_W'(1);
   assign col_end = (col_p1 == CMP_W'(eff_w));
   assign row_end = (cmps_pkg::dim_type'(row_ff + cmps_pkg::dim_type'(1)) == eff_h);

   // neighbour flags
   assign c_m  = (center_char == target_ff);
   assign up_e = is_drain ? (eff_h != cmps_pkg::dim_type'(1)) :
                            (row_ff > cmps_pkg::dim_type'(1));
   assign dn_e = is_pixel;
   assign dn_m = (req_ch.pixel_char == target_ff);
   assign lf_e = (col_ff != '0);
   assign rt_e = !col_end;
   assign rt_m = (right_char == target_ff);

   // cross decision
   assign erode_ok = c_m && (!up_e || up_match) && (!dn_e || dn_m) &&
                     (!lf_e || left_match_ff) && (!rt_e || rt_m);
   assign dilate_hit = c_m || (up_e && up_match) || (dn_e && dn_m) ||
                       (lf_e && left_match_ff) || (rt_e && rt_m);

   always_comb begin
      if (mode_ff == cmps_pkg::MODE_ERODE) begin
         out_char_in = erode_ok ? target_ff : background_ff;
      end else begin
         out_char_in = dilate_hit ? target_ff : center_char;
      end
   end

   // next frame position
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      priority if (restart) begin
         col_in      = '0;
         row_in      = '0;
         draining_in = 1'b0;
      end else if (is_pixel) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in      = '0;
               draining_in = 1'b1;
            end else begin
               row_in = cmps_pkg::dim_type'(row_ff + cmps_pkg::dim_type'(1));
            end
         end else begin
            col_in = col_p1[COL_W-1:0];
         end
      end else if (is_drain) begin
         if (col_end) begin
            col_in      = '0;
            row_in      = '0;
            draining_in = 1'b0;
         end else begin
            col_in = col_p1[COL_W-1:0];
         end
      end else begin
         col_in = col_ff;
      end
   end

   assign left_match_in = emit ? c_m : left_match_ff;
   assign rsp_valid_in  = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // line buffer: write at the current column, read ahead at the next one
   assign wr_en.char_we  = is_pixel;
   assign wr_en.match_we = emit;
   assign rd_b_addr      = (col_in == COL_LAST) ? '0 : col_in + COL_W'(1);

   cmps_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (col_ff),
      .wr_char    (req_ch.pixel_char),
      .wr_match   (c_m),
      .rd_a_addr  (col_in),
      .rd_b_addr  (rd_b_addr),
      .rd_a_char  (center_char),
      .rd_a_match (up_match),
      .rd_b_char  (right_char)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= cmps_pkg::MODE_ERODE;
         target_ff     <= cmps_pkg::TARGET_RESET;
         background_ff <= cmps_pkg::BACKGROUND_RESET;
         width_ff      <= cmps_pkg::DIM_RESET;
         height_ff     <= cmps_pkg::DIM_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            cmps_pkg::CSR_MODE:       mode_ff       <= csr_ch.data[0];
            cmps_pkg::CSR_TARGET:     target_ff     <= csr_ch.data[7:0];
            cmps_pkg::CSR_BACKGROUND: background_ff <= csr_ch.data[7:0];
            cmps_pkg::CSR_WIDTH:      width_ff      <= csr_ch.data;
            cmps_pkg::CSR_HEIGHT:     height_ff     <= csr_ch.data;
            default:                  mode_ff       <= mode_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         draining_ff   <= 1'b0;
         left_match_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         draining_ff   <= draining_in;
         left_match_ff <= left_match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_char_ff     <= out_char_in;
         end_of_row_ff   <= col_end;
         end_of_frame_ff <= col_end && is_drain;
      end
   end

   assign req_ch.ready        = req_ready;
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_char     = out_char_ff;
   assign rsp_ch.end_of_row   = end_of_row_ff;
   assign rsp_ch.end_of_frame = end_of_frame_ff;

endmodule
